>>> sv/iss_pkg.sv
// ----------------------------------------------------------------------------
// iss_pkg
// shared constants, codes and control structs for the integer set store
// ----------------------------------------------------------------------------
package iss_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int VAL_W   = 32;
  localparam int ACT_W   = 2;
  localparam int STAT_W  = 2;
  localparam int FILL_W  = 5;

  // action codes, code three behaves as a query
  localparam logic [ACT_W-1:0] ACT_ADD    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] ST_CHANGED = 2'd0;
  localparam logic [STAT_W-1:0] ST_SAME    = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic start;       // latch input item, read entry zero
    logic step;        // advance index, read next entry
    logic shift_wr;    // move current entry down one place
    logic miss_done;   // value absent: an add appends or is rejected
    logic hit_done;    // value present, set left as is
    logic remove_done; // value removed, count down
    logic load_out;    // load output register
  } iss_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;       // no entries held
    logic match;       // entry read equals operand
    logic at_last;     // entry read is the last valid one
    logic act_remove;  // item is a remove
  } iss_stat_t;

endpackage

>>> sv/iss_dp.sv
// ----------------------------------------------------------------------------
// iss_dp
// datapath: entry memory, operand, index and count registers, output register
// ----------------------------------------------------------------------------
module iss_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  iss_pkg::iss_cmd_t                cmd,
  output iss_pkg::iss_stat_t               stat,
  input  logic [iss_pkg::ACT_W-1:0]        in_action,
  input  logic signed [iss_pkg::VAL_W-1:0] in_value,
  output logic                             out_was_present,
  output logic [iss_pkg::STAT_W-1:0]       out_status,
  output logic [iss_pkg::FILL_W-1:0]       out_fill_count
);

  logic [iss_pkg::VAL_W-1:0]  mem [iss_pkg::ENTRIES];
  logic [iss_pkg::VAL_W-1:0]  rd_data_r;
  logic [iss_pkg::IDX_W-1:0]  rd_addr;
  logic [iss_pkg::IDX_W-1:0]  wr_addr;
  logic [iss_pkg::VAL_W-1:0]  wr_data;
  logic                       wr_en;

  logic [iss_pkg::ACT_W-1:0]  act_r;
  logic [iss_pkg::VAL_W-1:0]  value_r;
  logic [iss_pkg::IDX_W-1:0]  idx_r;
  logic [iss_pkg::CNT_W-1:0]  count_r;
  logic                       hit_r;
  logic [iss_pkg::STAT_W-1:0] status_r;
  logic                       room;
  logic                       append;

  logic                       out_was_present_r;
  logic [iss_pkg::STAT_W-1:0] out_status_r;
  logic [iss_pkg::FILL_W-1:0] out_fill_count_r;

  assign room   = count_r < iss_pkg::CNT_W'(iss_pkg::ENTRIES);
  assign append = cmd.miss_done && (act_r == iss_pkg::ACT_ADD) && room;

  always_comb begin
    rd_addr = cmd.start ? '0 : idx_r + iss_pkg::IDX_W'(1);
    wr_en   = cmd.shift_wr || append;
    wr_addr = cmd.shift_wr ? idx_r - iss_pkg::IDX_W'(1) : count_r[iss_pkg::IDX_W-1:0];
    wr_data = cmd.shift_wr ? rd_data_r : value_r;
  end

  // entry memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      act_r   <= in_action;
      value_r <= in_value;
    end
    if (cmd.start) begin
      idx_r <= '0;
    end else if (cmd.step) begin
      idx_r <= idx_r + iss_pkg::IDX_W'(1);
    end
    if (cmd.miss_done) begin
      hit_r <= 1'b0;
      if (act_r == iss_pkg::ACT_ADD) begin
        status_r <= room ? iss_pkg::ST_CHANGED : iss_pkg::ST_FULL;
      end else begin
        status_r <= iss_pkg::ST_SAME;
      end
    end else if (cmd.hit_done) begin
      hit_r    <= 1'b1;
      status_r <= iss_pkg::ST_SAME;
    end else if (cmd.remove_done) begin
      hit_r    <= 1'b1;
      status_r <= iss_pkg::ST_CHANGED;
    end
    if (cmd.load_out) begin
      out_was_present_r <= hit_r;
      out_status_r      <= status_r;
      out_fill_count_r  <= iss_pkg::FILL_W'(count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (append) begin
      count_r <= count_r + iss_pkg::CNT_W'(1);
    end else if (cmd.remove_done) begin
      count_r <= count_r - iss_pkg::CNT_W'(1);
    end
  end

  always_comb begin
    stat.empty      = count_r == '0;
    stat.match      = rd_data_r == value_r;
    stat.at_last    = (iss_pkg::CNT_W'(idx_r) + iss_pkg::CNT_W'(1)) == count_r;
    stat.act_remove = act_r == iss_pkg::ACT_REMOVE;
  end

  assign out_was_present = out_was_present_r;
  assign out_status      = out_status_r;
  assign out_fill_count  = out_fill_count_r;

endmodule

>>> sv/iss_ctrl.sv
// ----------------------------------------------------------------------------
// iss_ctrl
// controller: scan, shift and result hand-off sequencing
// ----------------------------------------------------------------------------
module iss_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  iss_pkg::iss_stat_t stat,
  output iss_pkg::iss_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    busy_nxt      = busy_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && !busy_r) begin
          cmd.start = 1'b1;
          busy_nxt  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.empty) begin
          cmd.miss_done = 1'b1;
          state_nxt     = S_EMIT;
        end else if (stat.match) begin
          if (!stat.act_remove) begin
            cmd.hit_done = 1'b1;
            state_nxt    = S_EMIT;
          end else if (stat.at_last) begin
            cmd.remove_done = 1'b1;
            state_nxt       = S_EMIT;
          end else begin
            cmd.step  = 1'b1;
            state_nxt = S_SHIFT;
          end
        end else if (stat.at_last) begin
          cmd.miss_done = 1'b1;
          state_nxt     = S_EMIT;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_SHIFT: begin
        cmd.shift_wr = 1'b1;
        if (stat.at_last) begin
          cmd.remove_done = 1'b1;
          state_nxt       = S_EMIT;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          busy_nxt      = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = busy_r;
  assign out_valid = out_valid_r;

endmodule

>>> sv/integer_set_store_core.sv
// scan: after an input transfer the entries held before the item are read one at a time
// through the single read port; a miss or a removal walks every entry, and a hit on a
// query or an add stops at its position
// one item at a time: a new transfer is taken only after the result of the last is
// loaded; a result held by out_stall delays the next load and transfer
// reset: synchronous active-low rst_n empties the set and drops out_valid; entries are kept
// ----------------------------------------------------------------------------
// integer_set_store_core
// set of distinct signed 32-bit integers with add, remove and query
// ----------------------------------------------------------------------------
module integer_set_store_core (
  input  logic                             clk,
  input  logic                             rst_n,
  // input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [iss_pkg::ACT_W-1:0]        in_action,
  input  logic signed [iss_pkg::VAL_W-1:0] in_value,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_was_present,
  output logic [iss_pkg::STAT_W-1:0]       out_status,
  output logic [iss_pkg::FILL_W-1:0]       out_fill_count
);

  // commands from the sequencer, status back from the datapath
  iss_pkg::iss_cmd_t  cmd;
  iss_pkg::iss_stat_t stat;

  // sequencer: takes one transfer while idle, walks the packed entries
  // until a match or the last valid one, closes the gap on a removal, then
  // waits for the output register to be free before loading the result
  iss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath: entry memory with registered read, operand latch, scan
  // index, fill count and the output register that holds a waiting result
  // while the next item is being worked on
  iss_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_action       (in_action),
    .in_value        (in_value),
    .out_was_present (out_was_present),
    .out_status      (out_status),
    .out_fill_count  (out_fill_count)
  );

endmodule

>>> sv/iss_checker.sv
// ----------------------------------------------------------------------------
// iss_checker
// port-level checks on the integer set store, bound to the top level
// ----------------------------------------------------------------------------
module iss_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic [iss_pkg::ACT_W-1:0]        in_action,
  input logic signed [iss_pkg::VAL_W-1:0] in_value,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic                             out_was_present,
  input logic [iss_pkg::STAT_W-1:0]       out_status,
  input logic [iss_pkg::FILL_W-1:0]       out_fill_count
);

  // a held result keeps valid and payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_was_present)
      && $stable(out_status) && $stable(out_fill_count))
    else $error("result changed while stalled");

  // a stalled input item keeps valid and payload
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_action) && $stable(in_value))
    else $error("input changed while stalled");

  // one item at a time: the cycle after a transfer the input is stalled
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after transfer");

  // a rejected add only happens on a full store with the value absent
  a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == iss_pkg::ST_FULL
      |-> !out_was_present && out_fill_count == iss_pkg::FILL_W'(iss_pkg::ENTRIES))
    else $error("full status inconsistent with count");

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind integer_set_store_core iss_checker u_iss_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .in_action       (in_action),
  .in_value        (in_value),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_was_present (out_was_present),
  .out_status      (out_status),
  .out_fill_count  (out_fill_count)
);
